FILE: src/dds_waveform_generator_registers_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the waveform generator checker
// Concurrent assertion shorthands used by the port checker.
// ---------------------------------------------------------------------------
`ifndef DDS_WAVEFORM_GENERATOR_REGISTERS_ASSERT_SVH
`define DDS_WAVEFORM_GENERATOR_REGISTERS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DWG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DWG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/dwg_pkg.sv
// ---------------------------------------------------------------------------
// Waveform generator package
// Shared constants, register word codes and the decoded control view.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwg_pkg;

  localparam int ACC_BITS_DEFAULT   = 28;
  localparam int PHASE_BITS_DEFAULT = 12;

  localparam int WORD_BITS    = 16;
  localparam int HALF_BITS    = 14;
  localparam int OFFSET_BITS  = 12;
  localparam int OUT_PH_BITS  = 12;
  localparam int TRI_BITS     = 10;

  // Control register bit positions.
  localparam int CTL_MODE    = 1;
  localparam int CTL_DIV2    = 3;
  localparam int CTL_OPBITEN = 5;
  localparam int CTL_SLEEP12 = 6;
  localparam int CTL_SLEEP1  = 7;
  localparam int CTL_RESET   = 8;
  localparam int CTL_PSELECT = 10;
  localparam int CTL_FSELECT = 11;
  localparam int CTL_B28     = 13;

  // Phase word: this bit picks the offset register.
  localparam int PHASE_REG_BIT = 13;

  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_TUNING0 = 2'd1,
    SEL_TUNING1 = 2'd2,
    SEL_PHASE   = 2'd3
  } word_sel_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    OUT_SINE     = 2'd0,
    OUT_TRIANGLE = 2'd1,
    OUT_SQUARE   = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic reset;
    logic sleep1;
    logic sleep12;
    logic fsel;
    logic psel;
    logic div2;
    logic opbiten;
    logic mode;
  } ctl_t;

endpackage

FILE: src/dwg_regs.sv
// ---------------------------------------------------------------------------
// Serial register file
// Decodes 16-bit register words into the control, frequency and phase
// registers, including the two-write 28-bit frequency load.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwg_regs #(
  parameter int ACC_BITS = dwg_pkg::ACC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic [dwg_pkg::WORD_BITS-1:0]      word,
  output dwg_pkg::ctl_t                      ctl,
  output logic [ACC_BITS-1:0]                tuning,
  output logic [dwg_pkg::OFFSET_BITS-1:0]    offset
);

  logic [dwg_pkg::HALF_BITS-1:0]   control;
  logic [dwg_pkg::HALF_BITS-1:0]   control_next;
  logic [ACC_BITS-1:0]             tw0;
  logic [ACC_BITS-1:0]             tw0_next;
  logic [ACC_BITS-1:0]             tw1;
  logic [ACC_BITS-1:0]             tw1_next;
  logic [dwg_pkg::OFFSET_BITS-1:0] off0;
  logic [dwg_pkg::OFFSET_BITS-1:0] off0_next;
  logic [dwg_pkg::OFFSET_BITS-1:0] off1;
  logic [dwg_pkg::OFFSET_BITS-1:0] off1_next;
  logic                            pending;
  logic                            pending_next;
  logic                            target;
  logic                            target_next;

  dwg_pkg::word_sel_t              sel;
  logic                            fidx;
  logic [ACC_BITS-1:0]             tw_cur;
  logic [ACC_BITS-1:0]             tw_upd;
  logic [2*dwg_pkg::HALF_BITS-1:0] high_val;

  assign sel    = dwg_pkg::word_sel_t'(word[dwg_pkg::WORD_BITS-1 -: 2]);
  assign fidx   = (sel == dwg_pkg::SEL_TUNING1);
  assign tw_cur = fidx ? tw1 : tw0;
  assign high_val = {word[dwg_pkg::HALF_BITS-1:0], tw_cur[dwg_pkg::HALF_BITS-1:0]};

  always_comb begin
    control_next = control;
    off0_next    = off0;
    off1_next    = off1;
    pending_next = pending;
    target_next  = target;
    tw_upd       = tw_cur;
    if (load) begin
      case (sel)
        dwg_pkg::SEL_CONTROL: begin
          control_next = word[dwg_pkg::HALF_BITS-1:0];
          pending_next = 1'b0;
        end
        dwg_pkg::SEL_PHASE: begin
          if (word[dwg_pkg::PHASE_REG_BIT]) begin
            off1_next = word[dwg_pkg::OFFSET_BITS-1:0];
          end else begin
            off0_next = word[dwg_pkg::OFFSET_BITS-1:0];
          end
        end
        default: begin
          // A second write to the same register completes the high half.
          if (control[dwg_pkg::CTL_B28] && pending && (target == fidx)) begin
            tw_upd       = ACC_BITS'(high_val);
            pending_next = 1'b0;
          end else begin
            tw_upd       = {tw_cur[ACC_BITS-1:dwg_pkg::HALF_BITS],
                            word[dwg_pkg::HALF_BITS-1:0]};
            pending_next = control[dwg_pkg::CTL_B28];
            if (control[dwg_pkg::CTL_B28]) begin
              target_next = fidx;
            end
          end
        end
      endcase
    end
    tw0_next = (load && sel == dwg_pkg::SEL_TUNING0) ? tw_upd : tw0;
    tw1_next = (load && sel == dwg_pkg::SEL_TUNING1) ? tw_upd : tw1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control <= '0;
      tw0     <= '0;
      tw1     <= '0;
      off0    <= '0;
      off1    <= '0;
      pending <= 1'b0;
      target  <= 1'b0;
    end else begin
      control <= control_next;
      tw0     <= tw0_next;
      tw1     <= tw1_next;
      off0    <= off0_next;
      off1    <= off1_next;
      pending <= pending_next;
      target  <= target_next;
    end
  end

  // The view reflects the word being written in this cycle.
  always_comb begin
    ctl.reset   = control_next[dwg_pkg::CTL_RESET];
    ctl.sleep1  = control_next[dwg_pkg::CTL_SLEEP1];
    ctl.sleep12 = control_next[dwg_pkg::CTL_SLEEP12];
    ctl.fsel    = control_next[dwg_pkg::CTL_FSELECT];
    ctl.psel    = control_next[dwg_pkg::CTL_PSELECT];
    ctl.div2    = control_next[dwg_pkg::CTL_DIV2];
    ctl.opbiten = control_next[dwg_pkg::CTL_OPBITEN];
    ctl.mode    = control_next[dwg_pkg::CTL_MODE];
  end

  assign tuning = control_next[dwg_pkg::CTL_FSELECT] ? tw1_next : tw0_next;
  assign offset = control_next[dwg_pkg::CTL_PSELECT] ? off1_next : off0_next;

endmodule

FILE: src/dds_waveform_generator_registers.sv
// ---------------------------------------------------------------------------
// Direct digital synthesizer with serial register interface
// Phase accumulator, phase offset, triangle and square derivation.
//
//   Channel   Handshake                  Payload
//   item      item_valid / item_stall    opcode, serial_word
//   result    result_valid / result_stall phase_out, triangle_code, square_bit,
//                                        output_select, dac_powered, in_reset
//
// Each result is registered and shows in the cycle after its transaction is
// accepted; a new transaction is accepted every cycle while item_stall is low.
// The accumulator and offset adds sit between the input port and the result
// register. Reset (rst, synchronous) zeroes all but the payload registers.
// item_stall is raised only while a result is held under result_stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_waveform_generator_registers #(
  parameter int ACC_BITS   = dwg_pkg::ACC_BITS_DEFAULT,
  parameter int PHASE_BITS = dwg_pkg::PHASE_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              opcode,
  input  logic [dwg_pkg::WORD_BITS-1:0]     serial_word,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [dwg_pkg::OUT_PH_BITS-1:0]   phase_out,
  output logic [dwg_pkg::TRI_BITS-1:0]      triangle_code,
  output logic                              square_bit,
  output logic [1:0]                        output_select,
  output logic                              dac_powered,
  output logic                              in_reset
);

  logic                                accept;
  logic                                load;
  dwg_pkg::ctl_t                       ctl;
  logic [ACC_BITS-1:0]                 tuning;
  logic [dwg_pkg::OFFSET_BITS-1:0]     offset;

  logic [ACC_BITS-1:0]                 acc;
  logic [ACC_BITS-1:0]                 acc_next;
  logic                                toggle;
  logic                                toggle_next;
  logic                                toggle_base;
  logic                                prev_msb;
  logic [PHASE_BITS-1:0]               phase;
  logic [PHASE_BITS+dwg_pkg::OUT_PH_BITS-1:0] phase_wide;
  logic [dwg_pkg::OUT_PH_BITS-1:0]     p12;
  logic                                msb;
  logic [dwg_pkg::TRI_BITS-1:0]        tri_val;
  dwg_pkg::out_sel_t                   sel_val;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign load       = accept && (opcode == dwg_pkg::OP_WRITE);

  dwg_regs #(
    .ACC_BITS (ACC_BITS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .word   (serial_word),
    .ctl    (ctl),
    .tuning (tuning),
    .offset (offset)
  );

  always_comb begin
    acc_next    = acc;
    toggle_base = toggle;
    if ((opcode == dwg_pkg::OP_TICK) && !ctl.reset && !ctl.sleep1) begin
      acc_next = acc + tuning;
    end
    if (ctl.reset) begin
      acc_next    = '0;
      toggle_base = 1'b0;
    end
    phase = acc_next[ACC_BITS-1 -: PHASE_BITS] + PHASE_BITS'(offset);
    // Align the phase to twelve bits, padding or dropping low bits.
    phase_wide  = {phase, {dwg_pkg::OUT_PH_BITS{1'b0}}};
    p12         = phase_wide[PHASE_BITS+dwg_pkg::OUT_PH_BITS-1 -: dwg_pkg::OUT_PH_BITS];
    msb         = p12[dwg_pkg::OUT_PH_BITS-1];
    toggle_next = toggle_base ^ (!ctl.reset && msb && !prev_msb);
    tri_val     = p12[dwg_pkg::TRI_BITS:1] ^ {dwg_pkg::TRI_BITS{msb}};
    if (ctl.opbiten) begin
      sel_val = dwg_pkg::OUT_SQUARE;
    end else if (ctl.mode) begin
      sel_val = dwg_pkg::OUT_TRIANGLE;
    end else begin
      sel_val = dwg_pkg::OUT_SINE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      toggle       <= 1'b0;
      prev_msb     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        acc          <= acc_next;
        toggle       <= toggle_next;
        prev_msb     <= msb;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      phase_out     <= dwg_pkg::OUT_PH_BITS'(phase);
      triangle_code <= tri_val;
      square_bit    <= ctl.div2 ? msb : toggle_next;
      output_select <= sel_val;
      dac_powered   <= !ctl.sleep12;
      in_reset      <= ctl.reset;
    end
  end

endmodule

FILE: src/dwg_checker.sv
// ---------------------------------------------------------------------------
// Port checker for the waveform generator
// Watches the top-level handshakes and result fields over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dds_waveform_generator_registers_assert.svh"

module dwg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_valid,
  input logic                            item_stall,
  input logic                            result_valid,
  input logic                            result_stall,
  input logic [dwg_pkg::OUT_PH_BITS-1:0] phase_out,
  input logic [1:0]                      output_select
);

  // A held result stays offered with the same phase.
  `DWG_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid && $stable(phase_out))

  // Input back-pressure only comes from a held result.
  `DWG_ASSERT_IMP(a_stall_cause, clk, rst, item_stall, result_valid && result_stall)

  // Every accepted transaction produces a result in the next cycle.
  `DWG_ASSERT_NEXT(a_accept_result, clk, rst, item_valid && !item_stall, result_valid)

  // The output select never takes the unused code.
  `DWG_ASSERT_IMP(a_select_code, clk, rst, result_valid, output_select != 2'd3)

endmodule

bind dds_waveform_generator_registers dwg_checker u_dwg_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_stall    (item_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .phase_out     (phase_out),
  .output_select (output_select)
);
